[sv/u8dec_pkg.sv]
// ----------------------------------------------------------------------------
// u8dec_pkg
// Shared types and constants for the UTF-8 to UTF-32 decoder.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int unsigned ByteW = 8;
    localparam int unsigned CpW   = 21;

    localparam logic [CpW-1:0] ReplChar = CpW'(24'h00FFFD);

    localparam logic [ByteW-1:0] ByteC0     = 8'hC0;
    localparam logic [ByteW-1:0] ByteC1     = 8'hC1;
    localparam logic [ByteW-1:0] MaskTop1   = 8'h80;
    localparam logic [ByteW-1:0] MaskTop2   = 8'hC0;
    localparam logic [ByteW-1:0] MaskTop3   = 8'hE0;
    localparam logic [ByteW-1:0] MaskTop4   = 8'hF0;
    localparam logic [ByteW-1:0] MaskTop5   = 8'hF8;
    localparam logic [ByteW-1:0] PfxCont    = 8'h80;
    localparam logic [ByteW-1:0] PfxLead2   = 8'hC0;
    localparam logic [ByteW-1:0] PfxLead3   = 8'hE0;
    localparam logic [ByteW-1:0] PfxLead4   = 8'hF0;
    localparam logic [ByteW-1:0] PayLead2   = 8'h1F;
    localparam logic [ByteW-1:0] PayLead3   = 8'h0F;
    localparam logic [ByteW-1:0] PayLead4   = 8'h07;
    localparam logic [ByteW-1:0] PayCont    = 8'h3F;

    // number of continuation bytes still expected
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2,
        PH_THREE = 2'd3
    } t_phase;

    typedef struct packed {
        logic [CpW-1:0] cp_word;
        logic           replaced;
    } t_result;

    typedef struct packed {
        logic           emit;
        t_result        res;
        t_phase         phase;
        logic [CpW-1:0] acc;
    } t_dec;

endpackage

[sv/u8dec_if.sv]
// ----------------------------------------------------------------------------
// u8dec_if
// Valid/ready channels: byte items in, code point items out.
// ----------------------------------------------------------------------------
interface u8dec_byte_if;
    logic                        valid;
    logic                        ready;
    logic [u8dec_pkg::ByteW-1:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface u8dec_cp_if;
    logic                      valid;
    logic                      ready;
    logic [u8dec_pkg::CpW-1:0] cp_word;
    logic                      replaced;

    modport source (output valid, output cp_word, output replaced, input ready);
    modport sink   (input valid, input cp_word, input replaced, output ready);
endinterface

[sv/u8dec_decode.sv]
// ----------------------------------------------------------------------------
// u8dec_decode
// Next-state and result logic for one byte.
// ----------------------------------------------------------------------------
module u8dec_decode (
    input  logic [u8dec_pkg::ByteW-1:0] i_byte,
    input  u8dec_pkg::t_phase           i_phase,
    input  logic [u8dec_pkg::CpW-1:0]   i_acc,
    output u8dec_pkg::t_dec             o_dec
);

    logic                      is_cont;
    logic [u8dec_pkg::CpW-1:0] pay6;

    assign is_cont = (i_byte & u8dec_pkg::MaskTop2) == u8dec_pkg::PfxCont;
    assign pay6    = u8dec_pkg::CpW'(i_byte & u8dec_pkg::PayCont);

    always_comb begin
        o_dec.emit         = 1'b0;
        o_dec.res.cp_word  = u8dec_pkg::ReplChar;
        o_dec.res.replaced = 1'b1;
        o_dec.phase        = i_phase;
        o_dec.acc          = i_acc;
        unique case (i_phase)
            u8dec_pkg::PH_START: begin
                priority if (i_byte == u8dec_pkg::ByteC0 || i_byte == u8dec_pkg::ByteC1) begin
                    o_dec.emit = 1'b1;
                    o_dec.acc  = '0;
                end else if ((i_byte & u8dec_pkg::MaskTop1) == '0) begin
                    o_dec.emit         = 1'b1;
                    o_dec.res.cp_word  = u8dec_pkg::CpW'(i_byte);
                    o_dec.res.replaced = 1'b0;
                end else if (is_cont) begin
                    o_dec.emit = 1'b0;
                end else if ((i_byte & u8dec_pkg::MaskTop3) == u8dec_pkg::PfxLead2) begin
                    o_dec.acc   = u8dec_pkg::CpW'(i_byte & u8dec_pkg::PayLead2) << 6;
                    o_dec.phase = u8dec_pkg::PH_ONE;
                end else if ((i_byte & u8dec_pkg::MaskTop4) == u8dec_pkg::PfxLead3) begin
                    o_dec.acc   = u8dec_pkg::CpW'(i_byte & u8dec_pkg::PayLead3) << 12;
                    o_dec.phase = u8dec_pkg::PH_TWO;
                end else if ((i_byte & u8dec_pkg::MaskTop5) == u8dec_pkg::PfxLead4) begin
                    o_dec.acc   = u8dec_pkg::CpW'(i_byte & u8dec_pkg::PayLead4) << 18;
                    o_dec.phase = u8dec_pkg::PH_THREE;
                end else begin
                    o_dec.emit = 1'b1;
                    o_dec.acc  = '0;
                end
            end
            u8dec_pkg::PH_THREE, u8dec_pkg::PH_TWO: begin
                if (!is_cont) begin
                    o_dec.emit  = 1'b1;
                    o_dec.phase = u8dec_pkg::PH_START;
                    o_dec.acc   = '0;
                end else if (i_phase == u8dec_pkg::PH_THREE) begin
                    o_dec.acc   = i_acc | (pay6 << 12);
                    o_dec.phase = u8dec_pkg::PH_TWO;
                end else begin
                    o_dec.acc   = i_acc | (pay6 << 6);
                    o_dec.phase = u8dec_pkg::PH_ONE;
                end
            end
            u8dec_pkg::PH_ONE: begin
                o_dec.emit  = 1'b1;
                o_dec.phase = u8dec_pkg::PH_START;
                o_dec.acc   = '0;
                if (is_cont) begin
                    o_dec.res.cp_word  = i_acc | pay6;
                    o_dec.res.replaced = 1'b0;
                end
            end
            default: begin
                o_dec.phase = u8dec_pkg::PH_START;
            end
        endcase
    end

endmodule

[sv/u8dec_out_reg.sv]
// ----------------------------------------------------------------------------
// u8dec_out_reg
// Result register driving the output channel.
// ----------------------------------------------------------------------------
module u8dec_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  u8dec_pkg::t_result i_res,
    output logic              o_free,
    u8dec_cp_if.source        o_cp
);

    logic               r_valid;
    u8dec_pkg::t_result r_res;

    assign o_free = !r_valid || o_cp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_cp.valid    = r_valid;
    assign o_cp.cp_word  = r_res.cp_word;
    assign o_cp.replaced = r_res.replaced;

endmodule

[sv/utf8_to_utf32_decoder_core.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf32_decoder_core
// Decodes a UTF-8 byte stream into UTF-32 code points.
//
//   Channel   Dir  Payload                     Per item
//   i_byte    in   byte_in[7:0]                one UTF-8 byte
//   o_cp      out  cp_word[20:0], replaced     zero or one per byte
//
// One byte per cycle sustained while o_cp is not stalled. A byte accepted into
// the input register is decoded combinationally from it, and its result is
// loaded into the output register once that register is free, and offered there.
// Stray continuation bytes and lead/middle bytes produce no item. Reset returns
// the phase to start and clears both register valids. An output stall holds the
// input register, even for a byte with no item, and so backs up to i_byte.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8dec_byte_if.sink  i_byte,
    u8dec_cp_if.source  o_cp
);

    logic                        r_in_valid;
    logic [u8dec_pkg::ByteW-1:0] r_in_byte;
    u8dec_pkg::t_phase           r_phase;
    logic [u8dec_pkg::CpW-1:0]   r_acc;
    u8dec_pkg::t_dec             n_dec;
    logic                        out_free;
    logic                        advance;

    assign advance      = r_in_valid && out_free;
    assign i_byte.ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= u8dec_pkg::PH_START;
            r_acc      <= '0;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (advance) begin
                r_phase <= n_dec.phase;
                r_acc   <= n_dec.acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.byte_in;
        end
    end

    u8dec_decode u_decode (
        .i_byte  (r_in_byte),
        .i_phase (r_phase),
        .i_acc   (r_acc),
        .o_dec   (n_dec)
    );

    u8dec_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && n_dec.emit),
        .i_res   (n_dec.res),
        .o_free  (out_free),
        .o_cp    (o_cp)
    );

endmodule
